FILE: hdl/xrg_pkg.sv
// Shared types, constants and helper functions for the xorshift64 range generator.
package xrg_pkg;

    localparam int XRG_DATA_W   = 64;
    localparam int XRG_RANGE_W  = 32;
    localparam int XRG_SPAN_W   = XRG_RANGE_W + 1;
    localparam int XRG_MAX_TRIES = 100;

    localparam int XRG_SHL_A = 13;
    localparam int XRG_SHR_B = 7;
    localparam int XRG_SHL_C = 17;

    localparam logic [XRG_DATA_W-1:0] XRG_ZERO_SUB   = 64'h0000_C0FF_EEC0_FFEE;
    localparam logic [XRG_DATA_W-1:0] XRG_SEED_RESET = 64'h0000_C0FF_EEC0_FFEE;

    typedef enum logic [1:0] {
        KIND_RAW  = 2'd0,
        KIND_MOD  = 2'd1,
        KIND_REJ  = 2'd2,
        KIND_SEED = 2'd3
    } t_kind;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [XRG_DATA_W-1:0] xrg_seed_value(input logic [XRG_DATA_W-1:0] s);
        xrg_seed_value = (s == '0) ? XRG_ZERO_SUB : s;
    endfunction

    function automatic logic [XRG_DATA_W-1:0] xrg_xs_step(input logic [XRG_DATA_W-1:0] s);
        logic [XRG_DATA_W-1:0] a;
        logic [XRG_DATA_W-1:0] b;
        a = s ^ (s << XRG_SHL_A);
        b = a ^ (a >> XRG_SHR_B);
        xrg_xs_step = b ^ (b << XRG_SHL_C);
    endfunction

endpackage

FILE: hdl/xrg_serdiv.sv
// Bit-serial restoring divider: remainder of a wide dividend by a narrow divisor.
module xrg_serdiv
    import xrg_pkg::*;
#(
    parameter int DVD_W = XRG_DATA_W,
    parameter int DVS_W = XRG_SPAN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVS_W-2:0] o_rem,
    output t_div_stat        o_stat
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam int REM_W = DVS_W - 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [REM_W-1:0] r_rem;

    logic [DVS_W-1:0] w_trial;
    logic [DVS_W-1:0] w_diff;
    logic [REM_W-1:0] n_rem;

    // one quotient bit per cycle; divisor is at most 2^REM_W so rem fits REM_W bits
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_trial - r_dvs;
        n_rem   = (w_trial >= r_dvs) ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hdl/xorshift64_range_generator_core.sv
// Top level of the xorshift64 range generator: request sequencer, state and output register.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one request: i_kind, i_range_low,
//   i_range_high. A transfer happens on a clock edge with valid high and stall low.
//   Output channel (o_out_valid / i_out_stall) carries one result per request:
//   range value, raw value (state - 1), current state and the gave-up flag.
//   i_seed_we / i_seed_data write the start seed; write only while the block is idle.
// Steps, request transfer to result valid
//   kind 0, kind 3, or range_low >= range_high : no remainder pass
//   kind 1 : one pass through the 64-step bit-serial remainder unit
//   kind 2 : up to MAX_TRIES draws and
//            two passes through the same serial remainder unit (bound, then modulo)
// Throughput: one request in flight; the next transfer is taken once the sequencer
//   is back in idle, even while the previous result still waits in the output register.
// Reset: synchronous, active low. Start seed and generator state go to 0xC0FFEEC0FFEE,
//   output register empties, sequencer idles.
// Receiver stall: the result holds in the output register; the sequencer waits for it
//   to free up before it loads the next result.
module xorshift64_range_generator_core
    import xrg_pkg::*;
#(
    parameter int MAX_TRIES = XRG_MAX_TRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_seed_we,
    input  logic [XRG_DATA_W-1:0]         i_seed_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic signed [XRG_RANGE_W-1:0] i_range_low,
    input  logic signed [XRG_RANGE_W-1:0] i_range_high,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [XRG_RANGE_W-1:0] o_range_value,
    output logic [XRG_DATA_W-1:0]         o_raw_value,
    output logic [XRG_DATA_W-1:0]         o_current_state,
    output logic                          o_gave_up
);

    localparam int TRY_W = $clog2(MAX_TRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_BOUND = 7'b0000100,
        S_DRAW  = 7'b0001000,
        S_TEST  = 7'b0010000,
        S_MOD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_fsm;

    t_fsm                          r_fsm;
    logic [XRG_DATA_W-1:0]         r_seed;
    logic [XRG_DATA_W-1:0]         r_state;
    logic [TRY_W-1:0]              r_tries;

    // latched request and work registers (no reset needed)
    t_kind                         r_kind;
    logic signed [XRG_RANGE_W-1:0] r_lo;
    logic signed [XRG_RANGE_W-1:0] r_hi;
    logic [XRG_DATA_W-1:0]         r_bound;
    logic [XRG_RANGE_W-1:0]        r_range;
    logic                          r_gave;

    // output register
    logic                          r_out_valid;
    logic signed [XRG_RANGE_W-1:0] r_out_range;
    logic [XRG_DATA_W-1:0]         r_out_raw;
    logic [XRG_DATA_W-1:0]         r_out_state;
    logic                          r_out_gave;

    logic                          w_in_xfer;
    logic                          w_out_xfer;
    logic                          w_out_free;
    logic                          w_load;
    logic                          w_empty;
    logic [XRG_SPAN_W-1:0]         w_diff;
    logic [XRG_SPAN_W-1:0]         w_n;
    logic [XRG_DATA_W-1:0]         w_draw;
    logic                          w_fits;
    logic                          w_div_start;
    logic [XRG_DATA_W-1:0]         w_div_dvd;
    logic [XRG_SPAN_W-2:0]         w_rem;
    t_div_stat                     w_div_stat;

    assign o_in_stall = (r_fsm != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_fsm == S_OUT) && w_out_free;

    // span n = hi - lo + 1, at most 2^32 when hi > lo
    always_comb begin
        w_empty = (r_lo >= r_hi);
        w_diff  = {r_hi[XRG_RANGE_W-1], r_hi} - {r_lo[XRG_RANGE_W-1], r_lo};
        w_n     = w_diff + 1'b1;
        w_draw  = r_state - 1'b1;
        w_fits  = (r_kind == KIND_MOD) || (w_draw <= r_bound);
    end

    // bound pass divides all-ones by n; modulo pass divides the accepted or, on give-up, the last draw
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = w_draw;
        case (r_fsm)
            S_START: begin
                if (r_kind == KIND_REJ && !w_empty) begin
                    w_div_start = 1'b1;
                    w_div_dvd   = '1;
                end
            end
            S_TEST: begin
                if (w_fits || r_tries == TRY_W'(MAX_TRIES)) begin
                    w_div_start = 1'b1;
                end
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    xrg_serdiv #(
        .DVD_W (XRG_DATA_W),
        .DVS_W (XRG_SPAN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_n),
        .o_rem      (w_rem),
        .o_stat     (w_div_stat)
    );

    // sequencer, seed and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_seed  <= XRG_SEED_RESET;
            r_state <= xrg_seed_value(XRG_SEED_RESET);
            r_tries <= '0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed_data;
            end
            case (r_fsm)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_fsm <= S_START;
                    end
                end
                S_START: begin
                    r_tries <= '0;
                    case (r_kind)
                        KIND_RAW: begin
                            r_state <= xrg_xs_step(r_state);
                            r_fsm   <= S_OUT;
                        end
                        KIND_SEED: begin
                            r_state <= xrg_seed_value(r_seed);
                            r_fsm   <= S_OUT;
                        end
                        KIND_MOD: begin
                            if (w_empty) begin
                                r_fsm <= S_OUT;
                            end else begin
                                r_state <= xrg_xs_step(r_state);
                                r_fsm   <= S_TEST;
                            end
                        end
                        default: begin
                            r_fsm <= w_empty ? S_OUT : S_BOUND;
                        end
                    endcase
                end
                S_BOUND: begin
                    if (w_div_stat.done) begin
                        r_fsm <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_state <= xrg_xs_step(r_state);
                    r_tries <= r_tries + 1'b1;
                    r_fsm   <= S_TEST;
                end
                S_TEST: begin
                    r_fsm <= w_div_start ? S_MOD : S_DRAW;
                end
                S_MOD: begin
                    if (w_div_stat.done) begin
                        r_fsm <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    // request latch and result work registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind <= t_kind'(i_kind);
            r_lo   <= i_range_low;
            r_hi   <= i_range_high;
        end
        case (r_fsm)
            S_START: begin
                r_gave  <= 1'b0;
                r_range <= ((r_kind == KIND_MOD || r_kind == KIND_REJ) && w_empty) ?
                           r_lo : '0;
            end
            S_BOUND: begin
                // floor(max/n)*n - 1 = max - (max mod n) - 1
                if (w_div_stat.done) begin
                    r_bound <= ~XRG_DATA_W'(w_rem) - 1'b1;
                end
            end
            S_TEST: begin
                if (!w_fits && r_tries == TRY_W'(MAX_TRIES)) begin
                    r_gave <= 1'b1;
                end
            end
            S_MOD: begin
                if (w_div_stat.done) begin
                    r_range <= r_lo + w_rem[XRG_RANGE_W-1:0];
                end
            end
            default: begin
                r_gave <= r_gave;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_range <= r_range;
            r_out_raw   <= w_draw;
            r_out_state <= r_state;
            r_out_gave  <= r_gave;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_range_value   = r_out_range;
    assign o_raw_value     = r_out_raw;
    assign o_current_state = r_out_state;
    assign o_gave_up       = r_out_gave;

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("remainder unit started while busy");

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != '0)
        else $error("generator state became zero");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_fsm == S_BOUND || r_fsm == S_MOD))
        else $error("remainder finished outside a wait state");

    a_tries_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= TRY_W'(MAX_TRIES))
        else $error("redraw count beyond limit");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the xorshift64 range generator core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xrg_pkg::*;

    // Cycle limit for the whole run. The slowest correct run is about 1600 requests,
    // each a rejection with every redraw, plus stall time.
    // This limit is several times that.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          RAND_PER_PHASE = 533;

    // One request as it appears on the request channel.
    typedef struct packed {
        t_kind                         kind;
        logic signed [XRG_RANGE_W-1:0] lo;
        logic signed [XRG_RANGE_W-1:0] hi;
    } draw_req_t;

    // One result as it appears on the result channel.
    typedef struct packed {
        logic signed [XRG_RANGE_W-1:0] range_value;
        logic [XRG_DATA_W-1:0]         raw_value;
        logic [XRG_DATA_W-1:0]         cur_state;
        logic                          gave_up;
    } draw_result_t;

    // All block inputs start at known values.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_seed_we = 1'b0;
    logic [XRG_DATA_W-1:0]         i_seed_data = '0;
    logic                          i_in_valid = 1'b0;
    logic [1:0]                    i_kind = '0;
    logic signed [XRG_RANGE_W-1:0] i_range_low = '0;
    logic signed [XRG_RANGE_W-1:0] i_range_high = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [XRG_RANGE_W-1:0] o_range_value;
    logic [XRG_DATA_W-1:0]         o_raw_value;
    logic [XRG_DATA_W-1:0]         o_current_state;
    logic                          o_gave_up;

    // Requests waiting to go on the bus, and results still owed by the block.
    draw_req_t    req_queue[$];
    draw_result_t owed_results[$];

    // Shadow copies of the seed register and the generator state.
    logic [XRG_DATA_W-1:0] shadow_seed = XRG_SEED_RESET;
    logic [XRG_DATA_W-1:0] shadow_state = XRG_SEED_RESET;

    int          send_idle_pct = 18;
    int          recv_idle_pct = 53;
    int          err_count = 0;
    int unsigned cycle_count = 0;
    draw_req_t   drv_item;
    draw_req_t   acc_item;

    xorshift64_range_generator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_data    (i_seed_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_range_value  (o_range_value),
        .o_raw_value    (o_raw_value),
        .o_current_state(o_current_state),
        .o_gave_up      (o_gave_up)
    );

    always #5 i_clk = ~i_clk;

    // One xorshift update: left 13, right 7, left 17.
    function automatic logic [XRG_DATA_W-1:0] xs_next(input logic [XRG_DATA_W-1:0] s);
        logic [XRG_DATA_W-1:0] t;
        t = s;
        t = t ^ {t[XRG_DATA_W-14:0], 13'b0};
        t = t ^ {7'b0, t[XRG_DATA_W-1:7]};
        t = t ^ {t[XRG_DATA_W-18:0], 17'b0};
        return t;
    endfunction

    // Expected result of one request; advances the shadow generator state.
    function automatic draw_result_t predict_draw(input draw_req_t rq);
        draw_result_t          r;
        logic signed [63:0]    lo_w;
        logic signed [63:0]    hi_w;
        logic [XRG_DATA_W-1:0] span;
        logic [XRG_DATA_W-1:0] accept_max;
        logic [XRG_DATA_W-1:0] val;
        bit                    hit;
        r = '0;
        lo_w = $signed(rq.lo);
        hi_w = $signed(rq.hi);
        case (rq.kind)
            KIND_RAW: begin
                shadow_state = xs_next(shadow_state);
            end
            KIND_SEED: begin
                shadow_state = (shadow_seed == '0) ? XRG_ZERO_SUB : shadow_seed;
            end
            default: begin
                if (lo_w >= hi_w) begin
                    // empty or one-value range: no draw, value is the low end
                    r.range_value = rq.lo;
                end else begin
                    span = hi_w - lo_w + 64'sd1;
                    val = '0;
                    if (rq.kind == KIND_MOD) begin
                        shadow_state = xs_next(shadow_state);
                        val = shadow_state - 1;
                    end else begin
                        // accept only draws below the largest multiple of span
                        accept_max = ({XRG_DATA_W{1'b1}} / span) * span - 1;
                        hit = 1'b0;
                        for (int t = 0; t < XRG_MAX_TRIES && !hit; t++) begin
                            shadow_state = xs_next(shadow_state);
                            val = shadow_state - 1;
                            hit = (val <= accept_max);
                        end
                        r.gave_up = !hit;
                    end
                    r.range_value = rq.lo + XRG_RANGE_W'(val % span);
                end
            end
        endcase
        r.raw_value = shadow_state - 1;
        r.cur_state = shadow_state;
        return r;
    endfunction

    function automatic draw_req_t random_req();
        draw_req_t rq;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 10) rq.kind = KIND_RAW;
        else if (pick < 45) rq.kind = KIND_MOD;
        else if (pick < 95) rq.kind = KIND_REJ;
        else rq.kind = KIND_SEED;
        rq.lo = $urandom;
        case ($urandom_range(9))
            0, 1, 2: rq.hi = $urandom;                 // anything, half are empty ranges
            3, 4, 5, 6: rq.hi = rq.lo + XRG_RANGE_W'($urandom_range(1, 1000));
            7: rq.hi = rq.lo;                          // single value
            8: begin                                   // full 32-bit span
                rq.lo = 32'sh8000_0000;
                rq.hi = 32'sh7FFF_FFFF;
            end
            default: rq.hi = rq.lo + XRG_RANGE_W'((64'd1 << $urandom_range(31)) - 1);
        endcase
        return rq;
    endfunction

    task automatic push_req(input t_kind k, input logic signed [31:0] lo,
                            input logic signed [31:0] hi);
        draw_req_t rq;
        rq.kind = k;
        rq.lo = lo;
        rq.hi = hi;
        req_queue.push_back(rq);
    endtask

    // Wait at falling edges until nothing is queued, on the bus or owed.
    task automatic wait_drained();
        @(negedge i_clk);
        while (req_queue.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Seed writes only with the block idle: waits until drained, then leaves a margin.
    task automatic write_seed(input logic [XRG_DATA_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_seed_we <= 1'b1;
        i_seed_data <= v;
        shadow_seed = v;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        i_seed_data <= {$urandom, $urandom};
    endtask

    // Request driver: predicts at each transfer, then offers the next queued request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                acc_item.kind = t_kind'(i_kind);
                acc_item.lo = i_range_low;
                acc_item.hi = i_range_high;
                owed_results.push_back(predict_draw(acc_item));
            end
            // payload may change only when nothing is held on the bus
            if (!i_in_valid || !o_in_stall) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = req_queue.pop_front();
                    i_kind <= drv_item.kind;
                    i_range_low <= drv_item.lo;
                    i_range_high <= drv_item.hi;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result monitor: every transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        draw_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: range_value %0d raw_value %h",
                       o_range_value, o_raw_value);
                err_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_range_value !== want.range_value) begin
                    $error("range_value: expected %0d, got %0d",
                           want.range_value, o_range_value);
                    err_count++;
                end
                if (o_raw_value !== want.raw_value) begin
                    $error("raw_value: expected %h, got %h", want.raw_value, o_raw_value);
                    err_count++;
                end
                if (o_current_state !== want.cur_state) begin
                    $error("current_state: expected %h, got %h",
                           want.cur_state, o_current_state);
                    err_count++;
                end
                if (o_gave_up !== want.gave_up) begin
                    $error("gave_up: expected %b, got %b", want.gave_up, o_gave_up);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset seed: every kind, range extremes, empty ranges.
        push_req(KIND_RAW,  32'sh8000_0000, 32'sh7FFF_FFFF);
        push_req(KIND_MOD,  32'sh8000_0000, 32'sh7FFF_FFFF);  // span of 2^32
        push_req(KIND_REJ,  32'sh8000_0000, 32'sh7FFF_FFFF);
        push_req(KIND_MOD,  32'sd5, 32'sd5);                   // single value
        push_req(KIND_REJ,  32'sh7FFF_FFFF, 32'sh8000_0000);   // low above high
        push_req(KIND_MOD,  32'sh8000_0000, 32'sh8000_0001);
        push_req(KIND_REJ,  32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
        push_req(KIND_MOD,  -32'sd1, 32'sd0);
        push_req(KIND_REJ,  32'sd0, 32'sd2);
        push_req(KIND_MOD,  32'sd0, 32'sd6);
        push_req(KIND_REJ,  -32'sd7, -32'sd5);
        push_req(KIND_MOD,  32'sh8000_0000, 32'sh8000_0000);
        push_req(KIND_REJ,  32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_req(KIND_SEED, 32'sh7FFF_FFFF, -32'sd1);          // range fields ignored
        push_req(KIND_RAW,  -32'sd1, 32'sh8000_0000);

        // Zero seed is replaced by the fixed constant on reload.
        write_seed('0);
        push_req(KIND_SEED, 32'sd0, 32'sd0);
        push_req(KIND_RAW,  32'sd0, 32'sd0);
        write_seed({XRG_DATA_W{1'b1}});
        push_req(KIND_SEED, 32'sd0, 32'sd0);
        push_req(KIND_MOD,  32'sd0, 32'sd9);
        write_seed(64'd1);
        push_req(KIND_SEED, 32'sd0, 32'sd0);
        push_req(KIND_RAW,  32'sd0, 32'sd0);
        push_req(KIND_REJ,  32'sd10, 32'sd20);

        // Random part in three idling phases, a fresh seed before each.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_seed(64'h8000_0000_0000_0000);
                default: write_seed({$urandom, $urandom});
            endcase
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 53 : 0;
            recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 18 : 0;
            push_req(KIND_SEED, 32'sd0, 32'sd0);
            for (int k = 0; k < RAND_PER_PHASE; k++)
                req_queue.push_back(random_req());
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
